// File: rtl/core/cdm_pkg.sv
// ----------------------------------------------------------------------------
// cdm_pkg
// Shared types and constants of the cosine distance matrix engine.
// ----------------------------------------------------------------------------
package cdm_pkg;

   localparam int ROW_W    = 6;
   localparam int COL_W    = 7;
   localparam int ELEM_W   = 16;
   localparam int MAX_ROWS = 64;
   localparam int MAX_COLS = 128;
   localparam int ADDR_W   = ROW_W + COL_W;
   localparam int DEPTH    = MAX_ROWS * MAX_COLS;
   localparam int DIST_W   = 18;
   localparam int SUM_W    = 38;
   localparam int DOT_W    = 40;
   localparam int NORM_W   = 19;
   localparam int DEN_W    = 38;
   localparam int DIVD_W   = 54;
   localparam int ONE_Q16  = 65536;

   typedef enum logic [1:0] {
      OP_WRITE_A = 2'd0,
      OP_WRITE_B = 2'd1,
      OP_COMPUTE = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_ROWS_A  = 2'd0,
      CSR_ROWS_B  = 2'd1,
      CSR_COLS    = 2'd2,
      CSR_MIN_DEN = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ERR,
      ST_NORM_A,
      ST_DOT,
      ST_SQRT,
      ST_MUL,
      ST_CHK,
      ST_DIV,
      ST_EMIT
   } state_type;

endpackage

// File: rtl/core/cdm_ram.sv
// ----------------------------------------------------------------------------
// cdm_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module cdm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/cosine_distance_matrix.sv
// ----------------------------------------------------------------------------
// cosine_distance_matrix
// Loads two vector stores and returns cosine distances of one A row to all
// used B rows.
// ----------------------------------------------------------------------------
// channel  dir  tdata / data                              tuser     tlast
// req      in   row[5:0] col[12:6] value[28:13]           op[1:0]   -
// rsp      out  a_index[5:0] b_index[11:6] distance[29:12] error    last
// csr      in   csr_index[1:0], csr_data[19:0]            -         -
//
// A compute item sums the squares of the A row and takes their root, then
// per B row reads the columns one at a time through the single read port of
// each store, takes the root of the B sum, forms the product, divides when it
// exceeds the minimum, and emits. Reset clears control only; the stores are
// not cleared. A stalled result holds the engine in emit.
// ----------------------------------------------------------------------------
module cosine_distance_matrix (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // row, col, value, zero fill
   input  logic [1:0]  req_tuser,   // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // a_index, b_index, distance, zero fill
   output logic        rsp_tuser,   // error
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [19:0] csr_data
);
   import cdm_pkg::*;

   state_type state_ff, state_in;

   logic [6:0]  rows_a_ff, rows_b_ff;
   logic [7:0]  cols_ff;
   logic [19:0] min_den_ff;

   logic [ROW_W-1:0]  row_ff, row_in;
   logic [ROW_W-1:0]  j_ff, j_in;
   logic [6:0]        nb_ff, nb_in;
   logic [7:0]        nc_ff, nc_in;
   logic [7:0]        issue_ff, issue_in;
   logic              rdv_ff, rdv_in;
   logic              a_phase_ff, a_phase_in;
   logic [SUM_W-1:0]  acc_a_ff, acc_a_in, acc_b_ff, acc_b_in;
   logic signed [DOT_W-1:0] dot_ff, dot_in;
   logic [NORM_W-1:0] norm_a_ff, norm_a_in;
   logic [SUM_W-1:0]  sq_x_ff, sq_x_in, sq_root_ff, sq_root_in, sq_bit_ff, sq_bit_in;
   logic [4:0]        sq_cnt_ff, sq_cnt_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic              neg_ff, neg_in;
   logic [SUM_W-1:0]  mag_ff, mag_in;
   logic [DIVD_W-1:0] dq_ff, dq_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [5:0]        dcnt_ff, dcnt_in;

   logic              out_valid_ff;
   logic [ROW_W-1:0]  out_a_ff, out_b_ff;
   logic [DIST_W-1:0] out_dist_ff, dist_value;
   logic              out_err_ff, out_last_ff;

   logic              req_acc, can_load, load_norm, load_err, issuing, drained, is_last;
   logic [ROW_W-1:0]  in_row;
   logic [COL_W-1:0]  in_col;
   logic [ELEM_W-1:0] in_value, a_rd, b_rd;
   op_type            in_op;
   logic              a_wr, b_wr;
   logic [ADDR_W-1:0] wr_addr, a_rd_addr, b_rd_addr;
   logic signed [31:0] a_sq, b_sq, ab;
   logic [SUM_W:0]    sq_trial;
   logic [DEN_W:0]    div_trial;
   logic [16:0]       q_clamp;

   assign in_row   = req_tdata[ROW_W-1:0];
   assign in_col   = req_tdata[ROW_W+COL_W-1:ROW_W];
   assign in_value = req_tdata[ROW_W+COL_W+ELEM_W-1:ROW_W+COL_W];
   assign in_op    = op_type'(req_tuser);

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign can_load   = !out_valid_ff || rsp_tready;

   assign a_wr    = req_acc && (in_op == OP_WRITE_A);
   assign b_wr    = req_acc && (in_op == OP_WRITE_B);
   assign wr_addr = {in_row, in_col};

   assign issuing   = (issue_ff < nc_ff) && ((state_ff == ST_NORM_A) || (state_ff == ST_DOT));
   assign drained   = !issuing && !rdv_ff;
   assign a_rd_addr = {row_ff, issue_ff[COL_W-1:0]};
   assign b_rd_addr = {j_ff, issue_ff[COL_W-1:0]};
   assign is_last   = ({1'b0, j_ff} + 7'd1) == nb_ff;

   cdm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_ram_a (
      .clock(clock), .wr_en(a_wr), .wr_addr(wr_addr), .wr_data(in_value),
      .rd_en(issuing), .rd_addr(a_rd_addr), .rd_data(a_rd)
   );

   cdm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_ram_b (
      .clock(clock), .wr_en(b_wr), .wr_addr(wr_addr), .wr_data(in_value),
      .rd_en(issuing), .rd_addr(b_rd_addr), .rd_data(b_rd)
   );

   assign a_sq = $signed(a_rd) * $signed(a_rd);
   assign b_sq = $signed(b_rd) * $signed(b_rd);
   assign ab   = $signed(a_rd) * $signed(b_rd);

   assign sq_trial  = {1'b0, sq_root_ff} + {1'b0, sq_bit_ff};
   assign div_trial = {rem_ff, dq_ff[DIVD_W-1]};

   assign q_clamp = ((|dq_ff[DIVD_W-1:17]) || (dq_ff[16:0] > 17'(ONE_Q16)))
                    ? 17'(ONE_Q16) : dq_ff[16:0];
   assign dist_value = neg_ff ? (DIST_W'(ONE_Q16) + {1'b0, q_clamp})
                              : (DIST_W'(ONE_Q16) - {1'b0, q_clamp});

   assign load_err  = (state_ff == ST_ERR) && can_load;
   assign load_norm = (state_ff == ST_EMIT) && can_load;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && (in_op == OP_COMPUTE)) begin
               state_in = ({1'b0, in_row} >= rows_a_ff) ? ST_ERR : ST_NORM_A;
            end
         end
         ST_ERR:    if (can_load) state_in = ST_IDLE;
         ST_NORM_A: if (drained) state_in = ST_SQRT;
         ST_DOT:    if (drained) state_in = ST_SQRT;
         ST_SQRT: begin
            if (sq_cnt_ff == 5'd18) state_in = a_phase_ff ? ST_DOT : ST_MUL;
         end
         ST_MUL:  state_in = ST_CHK;
         ST_CHK:  state_in = (den_ff > DEN_W'(min_den_ff)) ? ST_DIV : ST_EMIT;
         ST_DIV:  if (dcnt_ff == 6'(DIVD_W - 1)) state_in = ST_EMIT;
         ST_EMIT: if (can_load) state_in = is_last ? ST_IDLE : ST_DOT;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      row_in     = row_ff;
      j_in       = j_ff;
      nb_in      = nb_ff;
      nc_in      = nc_ff;
      issue_in   = issue_ff;
      rdv_in     = issuing;
      a_phase_in = a_phase_ff;
      acc_a_in   = acc_a_ff;
      acc_b_in   = acc_b_ff;
      dot_in     = dot_ff;
      norm_a_in  = norm_a_ff;
      sq_x_in    = sq_x_ff;
      sq_root_in = sq_root_ff;
      sq_bit_in  = sq_bit_ff;
      sq_cnt_in  = sq_cnt_ff;
      den_in     = den_ff;
      neg_in     = neg_ff;
      mag_in     = mag_ff;
      dq_in      = dq_ff;
      rem_in     = rem_ff;
      dcnt_in    = dcnt_ff;
      if (issuing) issue_in = issue_ff + 8'd1;
      unique case (state_ff)
         ST_IDLE: begin
            row_in     = in_row;
            j_in       = '0;
            issue_in   = '0;
            acc_a_in   = '0;
            acc_b_in   = '0;
            dot_in     = '0;
            a_phase_in = 1'b1;
            nb_in      = (rows_b_ff == 7'd0) ? 7'd1
                       : (rows_b_ff > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : rows_b_ff;
            nc_in      = (cols_ff > 8'(MAX_COLS)) ? 8'(MAX_COLS) : cols_ff;
         end
         ST_NORM_A: begin
            if (rdv_ff) acc_a_in = acc_a_ff + SUM_W'(a_sq[30:0]);
         end
         ST_DOT: begin
            if (rdv_ff) begin
               acc_b_in = acc_b_ff + SUM_W'(b_sq[30:0]);
               dot_in   = dot_ff + DOT_W'(ab);
            end
         end
         default: begin
         end
      endcase
      if ((state_ff == ST_NORM_A || state_ff == ST_DOT) && drained) begin
         sq_x_in    = a_phase_ff ? acc_a_ff : acc_b_ff;
         sq_root_in = '0;
         sq_bit_in  = SUM_W'(1) << 36;
         sq_cnt_in  = '0;
      end
      if (state_ff == ST_SQRT) begin
         if (sq_x_ff >= sq_trial[SUM_W-1:0] && !sq_trial[SUM_W]) begin
            sq_x_in    = sq_x_ff - sq_trial[SUM_W-1:0];
            sq_root_in = (sq_root_ff >> 1) + sq_bit_ff;
         end else begin
            sq_root_in = sq_root_ff >> 1;
         end
         sq_bit_in = sq_bit_ff >> 2;
         sq_cnt_in = sq_cnt_ff + 5'd1;
         if (sq_cnt_ff == 5'd18 && a_phase_ff) begin
            a_phase_in = 1'b0;
            issue_in   = '0;
            acc_b_in   = '0;
            dot_in     = '0;
            norm_a_in  = sq_root_in[NORM_W-1:0];
         end
      end
      if (state_ff == ST_MUL) begin
         den_in = DEN_W'(norm_a_ff * sq_root_ff[NORM_W-1:0]);
         neg_in = dot_ff[DOT_W-1];
         mag_in = dot_ff[DOT_W-1] ? SUM_W'(-dot_ff) : SUM_W'(dot_ff);
      end
      if (state_ff == ST_CHK) begin
         dq_in   = (den_ff > DEN_W'(min_den_ff)) ? {mag_ff, 16'd0} : '0;
         rem_in  = '0;
         dcnt_in = '0;
      end
      if (state_ff == ST_DIV) begin
         dcnt_in = dcnt_ff + 6'd1;
         if (div_trial >= {1'b0, den_ff}) begin
            rem_in = DEN_W'(div_trial - {1'b0, den_ff});
            dq_in  = {dq_ff[DIVD_W-2:0], 1'b1};
         end else begin
            rem_in = div_trial[DEN_W-1:0];
            dq_in  = {dq_ff[DIVD_W-2:0], 1'b0};
         end
      end
      if (load_norm && !is_last) begin
         j_in     = j_ff + 6'd1;
         issue_in = '0;
         acc_b_in = '0;
         dot_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rdv_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
         rows_a_ff    <= 7'd64;
         rows_b_ff    <= 7'd64;
         cols_ff      <= 8'd128;
         min_den_ff   <= 20'd1074;
      end else begin
         state_ff <= state_in;
         rdv_ff   <= rdv_in;
         if (load_err || load_norm) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            unique case (csr_index_type'(csr_index))
               CSR_ROWS_A:  rows_a_ff  <= csr_data[6:0];
               CSR_ROWS_B:  rows_b_ff  <= csr_data[6:0];
               CSR_COLS:    cols_ff    <= csr_data[7:0];
               CSR_MIN_DEN: min_den_ff <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      row_ff     <= row_in;
      j_ff       <= j_in;
      nb_ff      <= nb_in;
      nc_ff      <= nc_in;
      issue_ff   <= issue_in;
      a_phase_ff <= a_phase_in;
      acc_a_ff   <= acc_a_in;
      acc_b_ff   <= acc_b_in;
      dot_ff     <= dot_in;
      norm_a_ff  <= norm_a_in;
      sq_x_ff    <= sq_x_in;
      sq_root_ff <= sq_root_in;
      sq_bit_ff  <= sq_bit_in;
      sq_cnt_ff  <= sq_cnt_in;
      den_ff     <= den_in;
      neg_ff     <= neg_in;
      mag_ff     <= mag_in;
      dq_ff      <= dq_in;
      rem_ff     <= rem_in;
      dcnt_ff    <= dcnt_in;
      if (load_err) begin
         out_a_ff    <= row_ff;
         out_b_ff    <= '0;
         out_dist_ff <= '0;
         out_err_ff  <= 1'b1;
         out_last_ff <= 1'b1;
      end else if (load_norm) begin
         out_a_ff    <= row_ff;
         out_b_ff    <= j_ff;
         out_dist_ff <= dist_value;
         out_err_ff  <= 1'b0;
         out_last_ff <= is_last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_dist_ff, out_b_ff, out_a_ff};
   assign rsp_tuser  = out_err_ff;
   assign rsp_tlast  = out_last_ff;

endmodule
